@@ hw/rtl/cnep_pkg.sv @@
// ----------------------------------------------------------------------------
// cnep_pkg
// shared types, constants and helpers for the cellular noise edge pixel unit
// ----------------------------------------------------------------------------
package cnep_pkg;

	localparam int SCALE_W   = 14;
	localparam int D2_W      = 36;   // squared distance, Q.32
	localparam int F_W       = 18;   // sqrt of squared distance, Q.16
	localparam int NCELL     = 9;    // 3x3 neighborhood

	localparam logic [SCALE_W-1:0] SCALE_RESET = 14'd2048;
	localparam logic [31:0] MIX_C1      = 32'h85ebca6b;
	localparam logic [31:0] MIX_C2      = 32'hc2b2ae35;
	localparam logic [16:0] ONE_Q16     = 17'd65536;
	localparam logic [17:0] THREE_Q16   = 18'd196608;
	// edge*20 at or above this gives t above 1.0
	localparam logic [22:0] T_SAT_N     = 23'd196611;
	// ceil(2^19 / 3), exact floor(n/3) for n below 2^19
	localparam logic [17:0] DIV3_MUL    = 18'd174763;
	localparam int          DIV3_SHIFT  = 19;

	// two smallest squared distances of a group
	typedef struct packed {
		logic [D2_W-1:0] lo;
		logic [D2_W-1:0] hi;
	} pair_t;

	localparam logic [D2_W-1:0] D2_MAX = '1;

	function automatic pair_t merge_pair(input pair_t a, input pair_t b);
		pair_t r;
		if (a.lo <= b.lo) begin
			r.lo = a.lo;
			r.hi = (a.hi < b.lo) ? a.hi : b.lo;
		end else begin
			r.lo = b.lo;
			r.hi = (a.lo < b.hi) ? a.lo : b.hi;
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/cnep_isqrt.sv @@
// ----------------------------------------------------------------------------
// cnep_isqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module cnep_isqrt #(
	parameter int W = 36
) (
	input  logic           clk,
	input  logic           en,
	input  logic [W-1:0]   rad,
	output logic [W/2-1:0] root
);
	localparam int N = W / 2;

	logic [W-1:0]   rad_s  [1:N-1];
	logic [N+1:0]   rem_s  [1:N-1];
	logic [N-1:0]   root_s [1:N];

	for (genvar s = 0; s < N; s++) begin : g_stage
		logic [W-1:0] rin;
		logic [N+1:0] remin;
		logic [N-1:0] rootin;
		logic [N+3:0] cur;
		logic [N+3:0] trial;
		logic         take;

		if (s == 0) begin : g_first
			assign rin    = rad;
			assign remin  = '0;
			assign rootin = '0;
		end else begin : g_next
			assign rin    = rad_s[s];
			assign remin  = rem_s[s];
			assign rootin = root_s[s];
		end

		assign cur   = {remin, rin[W-1 -: 2]};
		assign trial = {2'b00, rootin, 2'b01};
		assign take  = (cur >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[s+1] <= {rootin[N-2:0], take};
			end
		end

		if (s < N - 1) begin : g_carry
			logic [N+3:0] diff;
			assign diff = cur - trial;
			always_ff @(posedge clk) begin
				if (en) begin
					rad_s[s+1] <= {rin[W-3:0], 2'b00};
					rem_s[s+1] <= take ? diff[N+1:0] : cur[N+1:0];
				end
			end
		end
	end

	assign root = root_s[N];

endmodule

@@ hw/rtl/cellular_noise_edge_pixel_unit.sv @@
// ----------------------------------------------------------------------------
// cellular_noise_edge_pixel_unit
// worley f2-f1 edge intensity per pixel, fully pipelined
// ----------------------------------------------------------------------------
// throughput: one word per cycle; the whole pipe advances together and holds
//   on an output stall (in_ready follows the output register's state)
// reset: clears all valid bits and sets the cell scale (scale_q) to 2048 (8.0); data
//   registers are not reset
module cellular_noise_edge_pixel_unit #(
	parameter int COORD_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COORD_BITS-1:0] u_coord,
	input  logic [COORD_BITS-1:0] v_coord,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [15:0]           intensity,
	input  logic                  cfg_we,
	input  logic [13:0]           cfg_wdata
);
	import cnep_pkg::*;

	localparam int PW    = COORD_BITS + SCALE_W;  // scaled coordinate width
	localparam int S_SQ  = 33;                    // smoothstep value registered
	localparam int LAST  = S_SQ + 17 + 1;         // output register

	// global advance: the pipe moves unless a word waits at the output
	logic adv;
	logic [LAST:1] vld_s;
	logic [SCALE_W-1:0] scale_q;

	assign adv       = ~vld_s[LAST] | out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_s[LAST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s   <= '0;
			scale_q <= SCALE_RESET;
		end else begin
			if (adv) vld_s <= {vld_s[LAST-1:1], in_valid};
			if (cfg_we) scale_q <= cfg_wdata;
		end
	end

	// s1: scale coordinates by cells per tile
	logic [PW-1:0] pu_s1, pv_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			pu_s1 <= PW'(u_coord) * PW'(scale_q);
			pv_s1 <= PW'(v_coord) * PW'(scale_q);
		end
	end

	// s2: cell index, fraction and the nine cell keys x + 127*y
	logic [5:0]  cx, cy;
	logic [15:0] fx_s2, fy_s2, fx_s3, fy_s3, fx_s4, fy_s4;
	logic [31:0] key_s2 [NCELL];
	logic [31:0] m1_s3  [NCELL];
	logic [31:0] m2_s4  [NCELL];
	logic signed [18:0] ex_s5 [NCELL];
	logic signed [18:0] ey_s5 [NCELL];
	logic [34:0] sqx_s6 [NCELL];
	logic [34:0] sqy_s6 [NCELL];
	logic [D2_W-1:0] d2_s7 [NCELL];

	assign cx = pu_s1[COORD_BITS+13 -: 6];
	assign cy = pv_s1[COORD_BITS+13 -: 6];

	always_ff @(posedge clk) begin
		if (adv) begin
			fx_s2 <= pu_s1[COORD_BITS+7 -: 16];
			fy_s2 <= pv_s1[COORD_BITS+7 -: 16];
			fx_s3 <= fx_s2;
			fy_s3 <= fy_s2;
			fx_s4 <= fx_s3;
			fy_s4 <= fy_s3;
		end
	end

	// one lane per neighbor cell, scan order dy outer, dx inner
	for (genvar l = 0; l < NCELL; l++) begin : g_lane
		localparam int DX = (l % 3) - 1;
		localparam int DY = (l / 3) - 1;
		logic [31:0] kx, ky, k, x1, x2, h;
		logic [15:0] hlo, hhi;
		logic [16:0] offx, offy;
		logic signed [18:0] ex, ey;
		logic signed [37:0] px, py;

		// key wraps in 32 bits, so negative keys come out two's complement
		assign kx = {26'b0, cx} + 32'(DX);
		assign ky = {26'b0, cy} + 32'(DY);
		assign k  = kx + (ky << 7) - ky;

		// murmur finalizer, one multiply per stage
		assign x1 = key_s2[l] ^ (key_s2[l] >> 16);
		assign x2 = m1_s3[l] ^ (m1_s3[l] >> 13);
		assign h  = m2_s4[l] ^ (m2_s4[l] >> 16);

		// feature point: each hash half in q.16, with all ones bumped to 1.0
		assign hlo  = h[15:0];
		assign hhi  = h[31:16];
		assign offx = {1'b0, hlo} + {16'b0, (hlo == 16'hFFFF)};
		assign offy = {1'b0, hhi} + {16'b0, (hhi == 16'hFFFF)};
		assign ex = $signed({3'b0, fx_s4}) - $signed(19'(DX * 65536)) - $signed({2'b0, offx});
		assign ey = $signed({3'b0, fy_s4}) - $signed(19'(DY * 65536)) - $signed({2'b0, offy});

		assign px = ex_s5[l] * ex_s5[l];
		assign py = ey_s5[l] * ey_s5[l];

		always_ff @(posedge clk) begin
			if (adv) begin
				key_s2[l] <= k;
				m1_s3[l]  <= x1 * MIX_C1;
				m2_s4[l]  <= x2 * MIX_C2;
				ex_s5[l]  <= ex;
				ey_s5[l]  <= ey;
				sqx_s6[l] <= px[34:0];
				sqy_s6[l] <= py[34:0];
				d2_s7[l]  <= D2_W'(sqx_s6[l]) + D2_W'(sqy_s6[l]);
			end
		end
	end

	// s8..s11: registered tree keeping the two smallest distances
	pair_t g1_s8 [5];
	pair_t g2_s9 [3];
	pair_t g3_s10 [2];
	pair_t best_s11;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				g1_s8[i] <= merge_pair('{lo: d2_s7[2*i], hi: D2_MAX},
					'{lo: d2_s7[2*i+1], hi: D2_MAX});
			end
			g1_s8[4]  <= '{lo: d2_s7[8], hi: D2_MAX};
			g2_s9[0]  <= merge_pair(g1_s8[0], g1_s8[1]);
			g2_s9[1]  <= merge_pair(g1_s8[2], g1_s8[3]);
			g2_s9[2]  <= g1_s8[4];
			g3_s10[0] <= merge_pair(g2_s9[0], g2_s9[1]);
			g3_s10[1] <= g2_s9[2];
			best_s11  <= merge_pair(g3_s10[0], g3_s10[1]);
		end
	end

	// s12..s29: f1 and f2 roots
	logic [F_W-1:0] f1, f2;

	cnep_isqrt #(.W(D2_W)) u_sqrt_f1 (
		.clk  (clk),
		.en   (adv),
		.rad  (best_s11.lo),
		.root (f1)
	);

	cnep_isqrt #(.W(D2_W)) u_sqrt_f2 (
		.clk  (clk),
		.en   (adv),
		.rad  (best_s11.hi),
		.root (f2)
	);

	// s30..s33: t = min(1, edge*20/3), then smoothstep
	logic [F_W-1:0]  edge_w;
	logic [22:0]     n_full;
	logic [17:0]     n_s30;
	logic            sat_s30;
	logic [35:0]     qprod;
	logic [16:0]     t_s31, t_s32, t2_s32, s_s33;
	logic [33:0]     tsq;
	logic [17:0]     fac;
	logic [34:0]     sprod;
	logic [17:0]     s_full;

	assign edge_w = f2 - f1;
	assign n_full = {edge_w, 4'b0} + {2'b0, edge_w, 2'b0};
	assign qprod  = n_s30 * DIV3_MUL;
	assign tsq    = t_s31 * t_s31;
	assign fac    = THREE_Q16 - {t_s32, 1'b0};
	assign sprod  = t2_s32 * fac;
	assign s_full = sprod[33:16];

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s30   <= n_full[17:0];
			sat_s30 <= (n_full >= T_SAT_N);
			t_s31   <= sat_s30 ? ONE_Q16 : qprod[DIV3_SHIFT+16:DIV3_SHIFT];
			t_s32   <= t_s31;
			t2_s32  <= tsq[32:16];
			s_s33   <= (s_full > 18'(ONE_Q16)) ? ONE_Q16 : s_full[16:0];
		end
	end

	// s34..s50: sqrt of (1 - s) in q.32
	logic [16:0] diff;
	logic [16:0] r;

	assign diff = ONE_Q16 - s_s33;

	cnep_isqrt #(.W(34)) u_sqrt_out (
		.clk  (clk),
		.en   (adv),
		.rad  ({1'b0, diff, 16'b0}),
		.root (r)
	);

	// s51: output register, 1.0 saturates to all ones
	logic [15:0] out_s51;
	always_ff @(posedge clk) begin
		if (adv) out_s51 <= r[16] ? 16'hFFFF : r[15:0];
	end
	assign intensity = out_s51;

endmodule

@@ bench/cellular_noise_edge_pixel_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cellular_noise_edge_pixel_checker
// watches both channels and the cell scale port, computes the edge intensity
// of every accepted coordinate word and compares it with the output words
// ----------------------------------------------------------------------------
module cellular_noise_edge_pixel_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [15:0] u_coord,
	input  logic [15:0] v_coord,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] intensity,
	input  logic        cfg_we,
	input  logic [13:0] cfg_wdata,
	output int          outstanding,
	output int          mismatches
);
	import cnep_pkg::*;

	logic [SCALE_W-1:0] scale_copy;
	logic [15:0]        pending_intensity[$];
	int                 word_count;

	function automatic longint unsigned int_sqrt(input longint unsigned x);
		longint unsigned res, bits;
		res = 0;
		bits = 64'd1 << 62;
		while (bits > x)
			bits >>= 2;
		while (bits != 0) begin
			if (x >= res + bits) begin
				x -= res + bits;
				res = (res >> 1) + bits;
			end else begin
				res >>= 1;
			end
			bits >>= 2;
		end
		return res;
	endfunction

	function automatic logic [31:0] murmur_mix(input logic [31:0] h);
		h = (h ^ (h >> 16)) * MIX_C1;
		h = (h ^ (h >> 13)) * MIX_C2;
		return h ^ (h >> 16);
	endfunction

	function automatic logic [15:0] edge_intensity(input logic [15:0] u, input logic [15:0] v,
			input logic [SCALE_W-1:0] sc);
		logic [29:0]     pu, pv;
		int              cx, cy;
		longint          fx, fy, ox, oy, ex, ey;
		logic [31:0]     key, h;
		longint unsigned d2, near1, near2, f1, f2, t, t2, s, r;
		pu = u * sc;
		pv = v * sc;
		cx = pu >> 24;
		cy = pv >> 24;
		fx = (pu >> 8) & 16'hffff;
		fy = (pv >> 8) & 16'hffff;
		near1 = '1;
		near2 = '1;
		for (int dy = -1; dy <= 1; dy++) begin
			for (int dx = -1; dx <= 1; dx++) begin
				// negative keys wrap in 32 bits
				key = (cx + dx) + 127 * (cy + dy);
				h = murmur_mix(key);
				ox = h[15:0] + (h[15:0] == 16'hffff);
				oy = h[31:16] + (h[31:16] == 16'hffff);
				ex = fx - dx * 65536 - ox;
				ey = fy - dy * 65536 - oy;
				d2 = ex * ex + ey * ey;
				if (d2 < near1) begin
					near2 = near1;
					near1 = d2;
				end else if (d2 < near2) begin
					near2 = d2;
				end
			end
		end
		f1 = int_sqrt(near1);
		f2 = int_sqrt(near2);
		t = (f2 - f1) * 20 / 3;
		if (t > 65536)
			t = 65536;
		t2 = (t * t) >> 16;
		s = (t2 * (196608 - 2 * t)) >> 16;
		if (s > 65536)
			s = 65536;
		r = int_sqrt((65536 - s) << 16);
		if (r > 65535)
			r = 65535;
		return r[15:0];
	endfunction

	task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
		$display("mismatch at word %0d: %s got %0d want %0d", word_count, what, got, want);
		mismatches++;
	endtask

	initial mismatches = 0;
	assign outstanding = pending_intensity.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_copy <= SCALE_RESET;
			word_count <= 0;
		end else begin
			if (cfg_we)
				scale_copy <= cfg_wdata;
			if (in_valid && in_ready)
				pending_intensity = {pending_intensity,
					edge_intensity(u_coord, v_coord, scale_copy)};
			if (out_valid && out_ready) begin
				if (pending_intensity.size() == 0) begin
					report("unexpected word", intensity, 16'd0);
				end else begin
					logic [15:0] want;
					want = pending_intensity.pop_front();
					if (intensity !== want)
						report("intensity", intensity, want);
				end
				word_count <= word_count + 1;
			end
		end
	end
endmodule

@@ bench/tb_cellular_noise_edge_pixel_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cellular_noise_edge_pixel_unit
// drives coordinate words through the edge pixel unit under several cell
// scales with bursty input and a stalling output; the checker does the rest
// ----------------------------------------------------------------------------
module tb_cellular_noise_edge_pixel_unit;
	import cnep_pkg::*;

	localparam int DRAIN_CYCLES = 60;   // longer than the pipe

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [15:0] u_coord = '0;
	logic [15:0] v_coord = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] intensity;
	logic        cfg_we = 1'b0;
	logic [13:0] cfg_wdata = '0;
	int          outstanding;
	int          mismatches;
	logic        hold_request = 1'b0;

	always #2 clk = ~clk;

	cellular_noise_edge_pixel_unit #(.COORD_BITS(16)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.u_coord(u_coord), .v_coord(v_coord),
		.out_valid(out_valid), .out_ready(out_ready), .intensity(intensity),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	cellular_noise_edge_pixel_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.u_coord(u_coord), .v_coord(v_coord),
		.out_valid(out_valid), .out_ready(out_ready), .intensity(intensity),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.outstanding(outstanding), .mismatches(mismatches)
	);

	// offer one coordinate word and wait for the unit to take it
	task automatic send_word(input logic [15:0] u, input logic [15:0] v);
		@(negedge clk);
		in_valid <= 1'b1;
		u_coord <= u;
		v_coord <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// drop valid and idle for some cycles
	task automatic idle_sender(input int cycles);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// wait for the pipe to empty, then write a new cell scale
	task automatic write_scale(input logic [13:0] value);
		idle_sender(0);
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// bursts of random words with random gaps; some runs go gap free
	task automatic random_words(input int count, input bit gapless);
		int sent, burst;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 24);
			for (int i = 0; i < burst && sent < count; i++) begin
				// now and then a coordinate right at an edge of the tile
				case ($urandom_range(0, 9))
					0: send_word(16'h0000, 16'($urandom));
					1: send_word(16'($urandom), 16'hffff);
					default: send_word(16'($urandom), 16'($urandom));
				endcase
				sent++;
			end
			if (!gapless && $urandom_range(0, 3) != 0)
				idle_sender($urandom_range(1, 8));
		end
	endtask

	// receiver: ready pattern changes every so often, plus one long hold-off
	// per request
	initial begin
		int mode, left, hold_left;
		bit hold_taken;
		mode = 0;
		left = 0;
		hold_left = 0;
		hold_taken = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_request) begin
				hold_taken = 1'b0;
			end else if (!hold_taken) begin
				hold_left = 400;
				hold_taken = 1'b1;
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(20, 200);
			end
			left--;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= 1'($urandom_range(0, 1));
				endcase
			end
		end
	end

	// stimulus
	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed: tile corners, center and smallest steps at reset scale
		send_word(16'h0000, 16'h0000);
		send_word(16'hffff, 16'hffff);
		send_word(16'h0000, 16'hffff);
		send_word(16'hffff, 16'h0000);
		send_word(16'h8000, 16'h8000);
		send_word(16'h0001, 16'h0001);
		send_word(16'hfffe, 16'h0001);
		send_word(16'h1fff, 16'h2000);
		send_word(16'haaaa, 16'h5555);
		send_word(16'h5555, 16'haaaa);

		// largest scale: many cells, fraction bits all live
		write_scale(14'h3fff);
		send_word(16'hffff, 16'hffff);
		send_word(16'h0000, 16'h0000);
		send_word(16'h0001, 16'hfffe);
		send_word(16'h8000, 16'h0123);
		// below range: zero gives cell 0, fraction 0
		write_scale(14'd0);
		send_word(16'hffff, 16'h1234);
		send_word(16'h0000, 16'hffff);
		write_scale(14'd1);
		send_word(16'hffff, 16'hffff);
		send_word(16'h4321, 16'h8765);
		// smallest in-range scale: a single cell
		write_scale(14'd256);
		send_word(16'hffff, 16'hffff);
		send_word(16'h0000, 16'h0000);
		send_word(16'h8000, 16'hffff);

		random_words(200, 1'b0);

		// long output hold-off while words keep coming so the pipe backs up
		hold_request <= 1'b1;
		random_words(120, 1'b1);
		hold_request <= 1'b0;

		write_scale(14'h3fff);
		random_words(200, 1'b0);
		// sender pauses until every word is back
		idle_sender(0);
		while (outstanding != 0)
			@(negedge clk);
		random_words(100, 1'b1);

		write_scale(14'd2048);
		random_words(200, 1'b0);
		write_scale(14'd0);
		random_words(40, 1'b0);
		for (int k = 0; k < 4; k++) begin
			write_scale(14'($urandom_range(0, 16383)));
			random_words(130, k[0]);
		end

		// drain
		idle_sender(0);
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end
endmodule
